// File: design/rft_pkg.sv
// shared constants and types of the rail fence transposer
// no dependencies; rft_if, rail_fence_transposer and rft_walker refer to it by scoped names
package rft_pkg;

	localparam int MAX_LEN = 64;
	localparam int ADDR_W  = $clog2(MAX_LEN);
	localparam int LEN_W   = ADDR_W + 1;
	localparam int SYM_W   = 8;
	localparam int RAIL_W  = 7;
	localparam int CYC_W   = RAIL_W + 1;
	localparam int NEXT_W  = ((ADDR_W > CYC_W) ? ADDR_W : CYC_W) + 1;
	localparam int IDX_W   = 1;
	localparam int DATA_W  = 7;

	typedef logic [IDX_W-1:0] reg_idx_t;
	localparam reg_idx_t REG_RAIL_COUNT  = 1'b0;
	localparam reg_idx_t REG_DECODE_MODE = 1'b1;

	localparam logic [RAIL_W-1:0] RAIL_RESET = 7'd3;

	// walker commands from the sequencer
	typedef struct packed {
		logic start;
		logic step;
	} walk_ctl_t;

endpackage

// File: design/rft_if.sv
// valid/ready channels of the rail fence transposer
// depends on rft_pkg for the payload widths
interface rft_in_if;
	logic                       valid;
	logic                       ready;
	logic [rft_pkg::SYM_W-1:0]  symbol_in;
	logic                       last_in;

	modport source (output valid, output symbol_in, output last_in, input ready);
	modport sink (input valid, input symbol_in, input last_in, output ready);
endinterface

interface rft_out_if;
	logic                       valid;
	logic                       ready;
	logic [rft_pkg::SYM_W-1:0]  symbol_out;
	logic                       last_out;
	logic                       overflow;

	modport source (output valid, output symbol_out, output last_out, output overflow,
		input ready);
	modport sink (input valid, input symbol_out, input last_out, input overflow,
		output ready);
endinterface

// File: design/rail_fence_transposer.sv
// Rail fence transposer: message bytes are loaded one per cycle into a 64-entry
// buffer until a request marked last arrives; bytes beyond 64 are dropped and every
// result of that message carries overflow. The whole message then leaves transposed
// over rail_count rails (0 and 1 pass it through unchanged). Encode produces each output
// byte in two steps (walker address, then the registered ram read). Decode first
// scatters the message into a second ram along the zigzag, a buffer read then a
// scratch write per byte, and then reads it out from that ram in order. The input is
// not ready from the last byte until the final result is taken. Configuration must be
// written through wr_en / wr_index / wr_data only while the block is idle (not enforced).
// depends on rft_pkg, rft_if, rft_ram and rft_walker
module rail_fence_transposer (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          wr_en,
	input  logic [rft_pkg::IDX_W-1:0]     wr_index,
	input  logic [rft_pkg::DATA_W-1:0]    wr_data,
	rft_in_if.sink                        msg,
	rft_out_if.source                     result
);

	typedef enum logic [4:0] {
		S_LOAD = 5'b00001,
		S_RD   = 5'b00010,
		S_OUT  = 5'b00100,
		S_SRD  = 5'b01000,
		S_SWR  = 5'b10000
	} state_t;

	state_t                       state_q;
	logic [rft_pkg::RAIL_W-1:0]   rail_count_q;
	logic                         decode_q;
	logic [rft_pkg::LEN_W-1:0]    len_q;
	logic                         ovf_q;
	logic [rft_pkg::ADDR_W-1:0]   cnt_q;

	logic [rft_pkg::RAIL_W-1:0]   rails_eff;
	logic [rft_pkg::ADDR_W-1:0]   pos;
	rft_pkg::walk_ctl_t           walk_ctl;
	logic                         in_fire;
	logic                         room;
	logic                         final_item;

	logic                         buf_we;
	logic                         buf_re;
	logic [rft_pkg::ADDR_W-1:0]   buf_raddr;
	logic [rft_pkg::SYM_W-1:0]    buf_rdata;
	logic                         scr_we;
	logic                         scr_re;
	logic [rft_pkg::SYM_W-1:0]    scr_rdata;

	always_comb begin
		rails_eff  = (rail_count_q == '0) ? rft_pkg::RAIL_W'(1) : rail_count_q;
		in_fire    = msg.valid && msg.ready;
		room       = len_q < rft_pkg::LEN_W'(rft_pkg::MAX_LEN);
		final_item = (rft_pkg::LEN_W'(cnt_q) + rft_pkg::LEN_W'(1)) == len_q;

		buf_we    = in_fire && room;
		buf_re    = (state_q == S_SRD) || ((state_q == S_RD) && !decode_q);
		buf_raddr = (state_q == S_SRD) ? cnt_q : pos;
		scr_we    = state_q == S_SWR;
		scr_re    = (state_q == S_RD) && decode_q;

		walk_ctl.start = in_fire && msg.last_in;
		walk_ctl.step  = (state_q == S_SWR) ||
			((state_q == S_OUT) && result.ready && !final_item);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rail_count_q <= rft_pkg::RAIL_RESET;
			decode_q     <= 1'b0;
		end else if (wr_en) begin
			case (wr_index)
				rft_pkg::REG_RAIL_COUNT:  rail_count_q <= wr_data[rft_pkg::RAIL_W-1:0];
				rft_pkg::REG_DECODE_MODE: decode_q     <= wr_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
			len_q   <= '0;
			ovf_q   <= 1'b0;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				S_LOAD: begin
					if (in_fire) begin
						if (room) begin
							len_q <= len_q + rft_pkg::LEN_W'(1);
						end else begin
							ovf_q <= 1'b1;
						end
						if (msg.last_in) begin
							cnt_q   <= '0;
							state_q <= decode_q ? S_SRD : S_RD;
						end
					end
				end
				S_RD: begin
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (result.ready) begin
						if (final_item) begin
							len_q   <= '0;
							ovf_q   <= 1'b0;
							state_q <= S_LOAD;
						end else begin
							cnt_q   <= cnt_q + rft_pkg::ADDR_W'(1);
							state_q <= S_RD;
						end
					end
				end
				S_SRD: begin
					state_q <= S_SWR;
				end
				// ciphertext byte cnt goes to its zigzag position in the scratch ram
				S_SWR: begin
					if (final_item) begin
						cnt_q   <= '0;
						state_q <= S_RD;
					end else begin
						cnt_q   <= cnt_q + rft_pkg::ADDR_W'(1);
						state_q <= S_SRD;
					end
				end
				default: begin
					state_q <= S_LOAD;
				end
			endcase
		end
	end

	rft_ram #(
		.DEPTH (rft_pkg::MAX_LEN),
		.WIDTH (rft_pkg::SYM_W)
	) u_buf (
		.clk   (clk),
		.we    (buf_we),
		.waddr (len_q[rft_pkg::ADDR_W-1:0]),
		.wdata (msg.symbol_in),
		.re    (buf_re),
		.raddr (buf_raddr),
		.rdata (buf_rdata)
	);

	rft_ram #(
		.DEPTH (rft_pkg::MAX_LEN),
		.WIDTH (rft_pkg::SYM_W)
	) u_scratch (
		.clk   (clk),
		.we    (scr_we),
		.waddr (pos),
		.wdata (buf_rdata),
		.re    (scr_re),
		.raddr (cnt_q),
		.rdata (scr_rdata)
	);

	rft_walker u_walker (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (walk_ctl),
		.rails  (rails_eff),
		.len    (len_q),
		.pos    (pos)
	);

	assign msg.ready         = state_q == S_LOAD;
	assign result.valid      = state_q == S_OUT;
	assign result.symbol_out = decode_q ? scr_rdata : buf_rdata;
	assign result.last_out   = final_item;
	assign result.overflow   = ovf_q;

endmodule

// File: design/rft_ram.sv
// generic single write, single read ram with registered read data
// no dependencies
module rft_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: design/rft_walker.sv
// zigzag position walker: steps through message positions rail by rail
// depends on rft_pkg
module rft_walker (
	input  logic                         clk,
	input  logic                         arst_n,
	input  rft_pkg::walk_ctl_t           ctl,
	input  logic [rft_pkg::RAIL_W-1:0]   rails,
	input  logic [rft_pkg::LEN_W-1:0]    len,
	output logic [rft_pkg::ADDR_W-1:0]   pos
);

	logic [rft_pkg::ADDR_W-1:0] rail_q;
	logic [rft_pkg::ADDR_W-1:0] pos_q;
	logic                       phase_q;

	logic [rft_pkg::CYC_W-1:0]  cycle_len;
	logic [rft_pkg::CYC_W-1:0]  twice_rail;
	logic [rft_pkg::CYC_W-1:0]  step_len;
	logic [rft_pkg::NEXT_W-1:0] next_pos;
	logic [rft_pkg::ADDR_W-1:0] next_rail;
	logic                       edge_rail;
	logic                       stay;

	always_comb begin
		cycle_len  = {rails - rft_pkg::RAIL_W'(1), 1'b0};
		twice_rail = rft_pkg::CYC_W'({rail_q, 1'b0});
		edge_rail  = (rail_q == '0) ||
			(rft_pkg::RAIL_W'(rail_q) == rails - rft_pkg::RAIL_W'(1));
		// middle rails alternate between the down and the up leg of the zigzag
		if (rails == rft_pkg::RAIL_W'(1)) begin
			step_len = rft_pkg::CYC_W'(1);
		end else if (edge_rail) begin
			step_len = cycle_len;
		end else if (phase_q) begin
			step_len = twice_rail;
		end else begin
			step_len = cycle_len - twice_rail;
		end
		next_pos  = rft_pkg::NEXT_W'(pos_q) + rft_pkg::NEXT_W'(step_len);
		stay      = next_pos < rft_pkg::NEXT_W'(len);
		next_rail = rail_q + rft_pkg::ADDR_W'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rail_q  <= '0;
			pos_q   <= '0;
			phase_q <= 1'b0;
		end else if (ctl.start) begin
			rail_q  <= '0;
			pos_q   <= '0;
			phase_q <= 1'b0;
		end else if (ctl.step) begin
			if (stay) begin
				pos_q   <= next_pos[rft_pkg::ADDR_W-1:0];
				phase_q <= ~phase_q;
			end else begin
				// next rail starts at its own index
				rail_q  <= next_rail;
				pos_q   <= next_rail;
				phase_q <= 1'b0;
			end
		end
	end

	assign pos = pos_q;

endmodule
